>>> rtl/core/vgrt_pkg.sv
// ============================================================================
// vgrt_pkg: shared types and constants of the voxel grid ray traversal
// Holds the field widths, register indexes and small records that the
// front, queue and walk units exchange.
// ============================================================================
`default_nettype none

package vgrt_pkg;

    // Fixed field widths.
    localparam int unsigned VOX_W     = 4;
    localparam int unsigned STEP_W    = 2;
    localparam int unsigned BINS_W    = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BINS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_Z = 2'd2;

    localparam logic [BINS_W-1:0] BINS_RESET = 5'd16;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Depth of the queue between the front and the walk unit.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [BINS_W-1:0] t_bins;
    typedef t_bins [2:0]       t_lims;
    typedef logic [VOX_W-1:0]  t_vox;

    // Decoded direction of one axis.
    typedef struct packed {
        logic en;
        logic neg;
    } t_dir;

    // Part of a queued ray that does not depend on the distance width.
    typedef struct packed {
        t_vox [2:0] vox;
        t_dir [2:0] dir;
    } t_head;

    localparam int unsigned HEAD_W = $bits(t_head);

endpackage

`default_nettype wire

>>> rtl/core/vgrt_if.sv
// ============================================================================
// vgrt_if: channel interfaces of the voxel grid ray traversal
// Ray request channel, voxel result channel and configuration write channel.
// ============================================================================
`default_nettype none

interface vgrt_ray_if #(
    parameter int unsigned DW = 32
);
    import vgrt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VOX_W-1:0]         start_x;
    logic [VOX_W-1:0]         start_y;
    logic [VOX_W-1:0]         start_z;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [STEP_W-1:0] step_z;
    logic [DW-1:0]            cross_x;
    logic [DW-1:0]            cross_y;
    logic [DW-1:0]            cross_z;
    logic [DW-1:0]            delta_x;
    logic [DW-1:0]            delta_y;
    logic [DW-1:0]            delta_z;

    modport source (
        output valid, start_x, start_y, start_z, step_x, step_y, step_z,
               cross_x, cross_y, cross_z, delta_x, delta_y, delta_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, step_x, step_y, step_z,
               cross_x, cross_y, cross_z, delta_x, delta_y, delta_z,
        output ready
    );
endinterface

interface vgrt_vox_if;
    import vgrt_pkg::*;

    logic             valid;
    logic             ready;
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
    logic             last;

    modport source (
        output valid, voxel_x, voxel_y, voxel_z, last,
        input  ready
    );
    modport sink (
        input  valid, voxel_x, voxel_y, voxel_z, last,
        output ready
    );
endinterface

interface vgrt_cfg_if;
    import vgrt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BINS_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/vgrt_front.sv
// ============================================================================
// vgrt_front: ray intake and classification
// Decodes the step signs, drops rays whose entry voxel lies outside the grid
// and packs the rest into one queue record.
// ============================================================================
`default_nettype none

module vgrt_front #(
    parameter int unsigned DW = 32
) (
    vgrt_ray_if.sink                                   i_ray,
    input  vgrt_pkg::t_lims                            i_lims,
    output logic                                       o_push_valid,
    input  logic                                       i_push_ready,
    output logic [vgrt_pkg::HEAD_W+6*DW-1:0]           o_push_data
);
    import vgrt_pkg::*;

    t_head head;
    logic  in_grid;

    // A raw sign of 01 is +1, any pattern with the top bit set is -1.
    function automatic t_dir decode_dir(input logic [STEP_W-1:0] raw);
        t_dir d;
        d.en  = |raw;
        d.neg = raw[1];
        return d;
    endfunction

    always_comb begin
        head.vox[0] = i_ray.start_x;
        head.vox[1] = i_ray.start_y;
        head.vox[2] = i_ray.start_z;
        head.dir[0] = decode_dir(i_ray.step_x);
        head.dir[1] = decode_dir(i_ray.step_y);
        head.dir[2] = decode_dir(i_ray.step_z);
        in_grid = ({1'b0, i_ray.start_x} < i_lims[0]) &&
                  ({1'b0, i_ray.start_y} < i_lims[1]) &&
                  ({1'b0, i_ray.start_z} < i_lims[2]);
    end

    // Rays outside the grid are taken and discarded without a queue slot.
    assign i_ray.ready  = i_push_ready | ~in_grid;
    assign o_push_valid = i_ray.valid & in_grid;
    assign o_push_data  = {head,
                           i_ray.cross_z, i_ray.cross_y, i_ray.cross_x,
                           i_ray.delta_z, i_ray.delta_y, i_ray.delta_x};

endmodule

`default_nettype wire

>>> rtl/core/vgrt_queue.sv
// ============================================================================
// vgrt_queue: short register queue
// Decouples the intake from the walk unit so that each can stall on its own.
// ============================================================================
`default_nettype none

module vgrt_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/vgrt_walk.sv
// ============================================================================
// vgrt_walk: voxel walk unit
// Loads one ray from the queue and steps it through the grid, one voxel per
// cycle while the output is not stalled, into a registered output stage.
// ============================================================================
`default_nettype none

module vgrt_walk #(
    parameter int unsigned DW = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vgrt_pkg::t_lims                    i_lims,
    input  logic                               i_pop_valid,
    output logic                               o_pop_ready,
    input  logic [vgrt_pkg::HEAD_W+6*DW-1:0]   i_pop_data,
    vgrt_vox_if.source                         o_vox
);
    import vgrt_pkg::*;

    localparam int unsigned REC_W = HEAD_W + 6 * DW;

    t_head             rec_head;
    logic [2:0][DW-1:0] rec_cross, rec_delta;

    // Walk state.
    logic               r_busy, n_busy;
    t_vox [2:0]         r_vox, n_vox;
    t_dir [2:0]         r_dir, n_dir;
    logic [2:0][DW-1:0] r_cross, n_cross;
    logic [2:0][DW-1:0] r_delta, n_delta;

    // Output stage.
    logic               r_ovalid, n_ovalid;
    t_vox [2:0]         r_ovox, n_ovox;
    logic               r_olast, n_olast;

    logic [2:0][DW:0]   key;
    logic [1:0]         axis;
    t_vox               sel_vox, next_vox;
    t_dir               sel_dir;
    t_bins              sel_lim;
    logic [DW:0]        sum;
    logic [DW-1:0]      sat;
    logic               leave, emit, load;

    assign rec_head = i_pop_data[REC_W-1 -: HEAD_W];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rec_delta[a] = i_pop_data[a*DW +: DW];
            rec_cross[a] = i_pop_data[(3+a)*DW +: DW];
        end
    end

    // A disabled axis gets a key just above every real distance.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            key[a] = r_dir[a].en ? {1'b0, r_cross[a]} : {1'b1, {DW{1'b0}}};
        end
        if (key[0] < key[1]) begin
            axis = (key[0] < key[2]) ? AXIS_X : AXIS_Z;
        end else begin
            axis = (key[1] < key[2]) ? AXIS_Y : AXIS_Z;
        end
    end

    always_comb begin
        sel_vox  = r_vox[axis];
        sel_dir  = r_dir[axis];
        sel_lim  = i_lims[axis];
        next_vox = sel_dir.neg ? sel_vox - 1'b1 : sel_vox + 1'b1;
        leave    = !(r_dir[0].en || r_dir[1].en || r_dir[2].en) ||
                   (sel_dir.neg ? (sel_vox == '0)
                                : (({1'b0, sel_vox} + 1'b1) >= sel_lim));
        sum      = {1'b0, r_cross[axis]} + {1'b0, r_delta[axis]};
        sat      = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
    end

    assign emit        = r_busy && (!r_ovalid || o_vox.ready);
    assign o_pop_ready = !r_busy;
    assign load        = !r_busy && i_pop_valid;

    always_comb begin
        n_busy   = r_busy;
        n_vox    = r_vox;
        n_dir    = r_dir;
        n_cross  = r_cross;
        n_delta  = r_delta;
        n_ovalid = r_ovalid;
        n_ovox   = r_ovox;
        n_olast  = r_olast;
        if (load) begin
            n_busy  = 1'b1;
            n_vox   = rec_head.vox;
            n_dir   = rec_head.dir;
            n_cross = rec_cross;
            n_delta = rec_delta;
        end
        if (emit) begin
            n_ovalid = 1'b1;
            n_ovox   = r_vox;
            n_olast  = leave;
            if (leave) begin
                n_busy = 1'b0;
            end else begin
                n_vox[axis]   = next_vox;
                n_cross[axis] = sat;
            end
        end else if (o_vox.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vox   <= n_vox;
        r_dir   <= n_dir;
        r_cross <= n_cross;
        r_delta <= n_delta;
        r_ovox  <= n_ovox;
        r_olast <= n_olast;
    end

    assign o_vox.valid   = r_ovalid;
    assign o_vox.voxel_x = r_ovox[0];
    assign o_vox.voxel_y = r_ovox[1];
    assign o_vox.voxel_z = r_ovox[2];
    assign o_vox.last    = r_olast;

endmodule

`default_nettype wire

>>> rtl/core/voxel_grid_ray_traversal.sv
// ============================================================================
// voxel_grid_ray_traversal: 3D voxel walk of rays through a regular grid
// Top level: configuration registers, ray intake, queue and walk unit.
// ============================================================================
// Each request on i_ray is one ray's start state: entry voxel, step sign per
// axis, distance to the first plane crossing and distance across one voxel
// per axis (unsigned Q16.16 in DIST_WIDTH bits). The block returns the visited
// voxels on o_vox in order, entry voxel first, and marks the final one with
// last. At each step the axis with the smallest crossing distance advances,
// a tie going to the later axis (z before y, y before x), and its distance
// grows by its increment, saturating at the largest value. A ray whose entry
// voxel is outside the grid gives no result and takes no queue slot. A ray
// whose steps are all zero gives only its entry voxel. The walk unit produces
// one voxel per cycle while o_vox does not stall, and loads a ray only after
// the previous walk ends; that single stepping loop sets the throughput. A
// two-entry queue lets the intake take the next rays while a walk is in
// progress. The output register lets the walk produce the next voxel in the
// same cycle that the previous one is taken; while a voxel waits on o_vox,
// the walk stalls with it. Grid sizes are written on i_cfg (always ready);
// the user must write them only while the block is idle; the block does not
// enforce this. A size above MAX_BINS acts as MAX_BINS; zero drops every ray.
// ============================================================================
`default_nettype none

module voxel_grid_ray_traversal #(
    parameter int unsigned MAX_BINS   = 16,
    parameter int unsigned DIST_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vgrt_cfg_if.sink   i_cfg,
    vgrt_ray_if.sink   i_ray,
    vgrt_vox_if.source o_vox
);
    import vgrt_pkg::*;

    localparam int unsigned REC_W = HEAD_W + 6 * DIST_WIDTH;

    t_bins r_bins_x, r_bins_y, r_bins_z;
    t_lims lims;

    logic             push_valid, push_ready;
    logic [REC_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [REC_W-1:0] pop_data;

    // Configuration writes are always accepted. Indexes beyond the
    // register list are accepted and ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_x <= BINS_RESET;
            r_bins_y <= BINS_RESET;
            r_bins_z <= BINS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BINS_X: begin
                    r_bins_x <= i_cfg.data;
                end
                REG_BINS_Y: begin
                    r_bins_y <= i_cfg.data;
                end
                REG_BINS_Z: begin
                    r_bins_z <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Grid sizes above the supported maximum are clamped to it.
    function automatic t_bins clamp_bins(input t_bins b);
        return (b > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : b;
    endfunction

    assign lims[0] = clamp_bins(r_bins_x);
    assign lims[1] = clamp_bins(r_bins_y);
    assign lims[2] = clamp_bins(r_bins_z);

    vgrt_front #(
        .DW (DIST_WIDTH)
    ) u_front (
        .i_ray        (i_ray),
        .i_lims       (lims),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    vgrt_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    vgrt_walk #(
        .DW (DIST_WIDTH)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lims      (lims),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_vox       (o_vox)
    );

endmodule

`default_nettype wire

>>> rtl/core/vgrt_checker.sv
// ============================================================================
// vgrt_checker: port-level checks of the voxel grid ray traversal
// Watches the result channel over time and is bound to the top level.
// ============================================================================
`default_nettype none

module vgrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_voxel_x,
    input logic [3:0] i_voxel_y,
    input logic [3:0] i_voxel_z,
    input logic       i_last
);

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_voxel_x) && $stable(i_voxel_y) &&
             $stable(i_voxel_z) && $stable(i_last)))
        else $error("stalled result changed");

    // Within a ray the next voxel follows in the very next cycle.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=> i_out_valid)
        else $error("gap inside a ray walk");

    // Consecutive voxels of one ray differ along exactly one axis.
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=>
            ($countones({i_voxel_x != $past(i_voxel_x),
                         i_voxel_y != $past(i_voxel_y),
                         i_voxel_z != $past(i_voxel_z)}) == 1))
        else $error("walk moved along other than one axis");

endmodule

bind voxel_grid_ray_traversal vgrt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_vox.valid),
    .i_out_ready (o_vox.ready),
    .i_voxel_x   (o_vox.voxel_x),
    .i_voxel_y   (o_vox.voxel_y),
    .i_voxel_z   (o_vox.voxel_z),
    .i_last      (o_vox.last)
);

`default_nettype wire
